// File: rtl/sobet_pkg.sv
`default_nettype none

package sobet_pkg;

	// Pixel and arithmetic widths.
	localparam int PIX_W    = 8;
	localparam int GRAD_W   = 11;
	localparam int SQ_W     = 20;
	localparam int MAG_W    = 21;
	localparam int THR_W    = 11;
	localparam int THR_SQ_W = 23;
	localparam int CFG_W    = 12;
	localparam int HGT_W    = 12;
	localparam int ROW_W    = 11;

	// Geometry limits and register defaults.
	localparam int MIN_DIM         = 3;
	localparam int MAX_HEIGHT      = 2048;
	localparam int RESET_WIDTH     = 640;
	localparam int RESET_HEIGHT    = 480;
	localparam int RESET_THRESHOLD = 75;
	localparam logic [THR_SQ_W-1:0] RESET_THR_SQ =
		THR_SQ_W'((RESET_THRESHOLD + 1) * (RESET_THRESHOLD + 1));

	// Output levels.
	localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	// Input item function codes.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	typedef struct packed {
		logic             func;
		logic [PIX_W-1:0] gray_pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic [MAG_W-1:0] magnitude_sq;
		logic             frame_last;
	} out_item_t;

	// One queued result: gradients (zero at the border) and the frame end mark.
	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic                     frame_last;
	} grad_t;

endpackage

`default_nettype wire

// File: rtl/sobet_ram.sv
`default_nettype none

module sobet_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/sobet_queue.sv
`default_nettype none

module sobet_queue import sobet_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire grad_t             push_data,
	input  wire logic              pop,
	output grad_t                  head,
	output logic                   not_empty,
	output logic      [QCNT_W-1:0] count
);

	grad_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

`ifndef SYNTH
	// The front reserves room, so a push never meets a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCNT_W'(QUEUE_DEPTH)) || pop)
		else $error("queue push while full");

	// A pop is only issued while an entry is held.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// File: rtl/sobet_front.sv
`default_nettype none

module sobet_front import sobet_pkg::*; #(
	parameter int MAX_WIDTH = 2048,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 restart,
	input  wire logic [WW-1:0]        img_width,
	input  wire logic [HGT_W-1:0]     img_height,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	input  wire logic [QCNT_W-1:0]    q_count,
	output logic                      push,
	output grad_t                     push_data,
	output logic                      ram_rd_en,
	output logic      [AW-1:0]        ram_rd_addr,
	input  wire logic [2*PIX_W-1:0]   ram_rd_data,
	output logic                      ram_wr_en,
	output logic      [AW-1:0]        ram_wr_addr,
	output logic      [2*PIX_W-1:0]   ram_wr_data
);

	localparam int PW = $clog2(MAX_WIDTH + 2);

	// Stream position counters.
	logic [AW-1:0]    col_q;
	logic [PW-1:0]    pend_q;
	logic [AW-1:0]    qc_q;
	logic [ROW_W-1:0] qr_q;

	// Window columns: 0..2 oldest column top..bottom, 3..5 middle column.
	logic [PIX_W-1:0] win_q [6];

	// Line read stage.
	logic             valid_s1;
	logic             flush_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [AW-1:0]    addr_s1;
	logic             emit_s1;
	logic             inner_s1;
	logic             last_s1;

	logic             accept;
	logic             is_flush;
	logic [WW-1:0]    w_m1;
	logic [WW-1:0]    w_m2;
	logic [HGT_W-1:0] h_m1;
	logic [HGT_W-1:0] h_m2;
	logic             at_row_end;
	logic             at_last_row;
	logic             inner;
	logic             tail;
	logic             emit;
	logic             last;

	logic [PIX_W-1:0] top;
	logic [PIX_W-1:0] mid;
	logic [PIX_W+1:0] col_left;
	logic [PIX_W+1:0] col_right;
	logic [PIX_W+1:0] row_top;
	logic [PIX_W+1:0] row_bot;
	logic signed [GRAD_W-1:0] gx;
	logic signed [GRAD_W-1:0] gy;

	// Room is held back for the item in the line read stage.
	assign in_ready = (q_count + QCNT_W'(valid_s1)) < QCNT_W'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign is_flush = (in_data.func == FUNC_FLUSH);

	// Classify the item against the position of the next output pixel.
	always_comb begin
		w_m1        = img_width - WW'(1);
		w_m2        = img_width - WW'(2);
		h_m1        = img_height - HGT_W'(1);
		h_m2        = img_height - HGT_W'(2);
		at_row_end  = (WW'(qc_q) == w_m1);
		at_last_row = (HGT_W'(qr_q) == h_m1);
		inner       = !is_flush && (qr_q != '0) && (HGT_W'(qr_q) <= h_m2)
			&& (qc_q != '0) && (WW'(qc_q) <= w_m2);
		tail        = at_last_row || ((HGT_W'(qr_q) == h_m2) && at_row_end);
		last        = at_last_row && at_row_end;
		if (is_flush) begin
			emit = (pend_q != '0) && tail;
		end else begin
			emit = (pend_q >= (PW'(img_width) + PW'(1)));
		end
	end

	// Input column, outstanding count and output position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			pend_q <= '0;
			qc_q   <= '0;
			qr_q   <= '0;
		end else if (restart) begin
			col_q  <= '0;
			pend_q <= '0;
			qc_q   <= '0;
			qr_q   <= '0;
		end else if (accept) begin
			if (!is_flush) begin
				col_q <= (WW'(col_q) == w_m1) ? '0 : col_q + 1'b1;
			end
			pend_q <= pend_q + PW'(!is_flush) - PW'(emit);
			if (emit) begin
				if (at_row_end) begin
					qc_q <= '0;
					qr_q <= at_last_row ? '0 : qr_q + 1'b1;
				end else begin
					qc_q <= qc_q + 1'b1;
				end
			end
		end
	end

	// Line store read for the incoming pixel.
	assign ram_rd_en   = accept && !is_flush;
	assign ram_rd_addr = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && !restart;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flush_s1 <= is_flush;
			pixel_s1 <= in_data.gray_pixel;
			addr_s1  <= col_q;
			emit_s1  <= emit;
			inner_s1 <= inner;
			last_s1  <= last;
		end
	end

	// Sobel sums over the 3x3 window; the right column comes from the line stores and the incoming pixel.
	always_comb begin
		top       = ram_rd_data[2*PIX_W-1:PIX_W];
		mid       = ram_rd_data[PIX_W-1:0];
		col_left  = {2'b00, win_q[0]} + {1'b0, win_q[1], 1'b0} + {2'b00, win_q[2]};
		col_right = {2'b00, top} + {1'b0, mid, 1'b0} + {2'b00, pixel_s1};
		row_top   = {2'b00, win_q[0]} + {1'b0, win_q[3], 1'b0} + {2'b00, top};
		row_bot   = {2'b00, win_q[2]} + {1'b0, win_q[5], 1'b0} + {2'b00, pixel_s1};
		gx        = GRAD_W'({1'b0, col_left}) - GRAD_W'({1'b0, col_right});
		gy        = GRAD_W'({1'b0, row_top}) - GRAD_W'({1'b0, row_bot});
	end

	// Window shift on each pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1 && !flush_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= pixel_s1;
		end
	end

	// Line stores move down one row at this column.
	assign ram_wr_en   = valid_s1 && !flush_s1;
	assign ram_wr_addr = addr_s1;
	assign ram_wr_data = {mid, pixel_s1};

	// Hand the result to the back part; border positions carry zero gradients.
	assign push                 = valid_s1 && emit_s1;
	assign push_data.gx         = inner_s1 ? gx : '0;
	assign push_data.gy         = inner_s1 ? gy : '0;
	assign push_data.frame_last = last_s1;

`ifndef SYNTH
	// At most one row plus one pixel is ever outstanding.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= (PW'(img_width) + PW'(1)))
		else $error("outstanding pixel count beyond one row");

	// The line store write never lands on the column being read.
	a_ram_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && ram_rd_en) |-> ram_wr_addr != ram_rd_addr)
		else $error("line store read and write at the same column");
`endif

endmodule

`default_nettype wire

// File: rtl/sobet_back.sv
`default_nettype none

module sobet_back import sobet_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [THR_SQ_W-1:0] thr_sq,
	input  wire logic                q_valid,
	input  wire grad_t               q_head,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_data
);

	logic                     valid_s2;
	logic [SQ_W-1:0]          gx_sq_s2;
	logic [SQ_W-1:0]          gy_sq_s2;
	logic                     last_s2;
	logic                     valid_s3;
	out_item_t                data_s3;

	logic                     out_free;
	logic                     s2_free;
	logic signed [2*GRAD_W-1:0] gx_prod;
	logic signed [2*GRAD_W-1:0] gy_prod;
	logic [MAG_W-1:0]         mag;

	assign out_free = !valid_s3 || out_ready;
	assign s2_free  = !valid_s2 || out_free;
	assign q_pop    = q_valid && s2_free;

	// Squares of the gradients.
	assign gx_prod = q_head.gx * q_head.gx;
	assign gy_prod = q_head.gy * q_head.gy;

	// Sum of squares against the squared threshold.
	assign mag = MAG_W'(gx_sq_s2) + MAG_W'(gy_sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= q_valid;
			end
			if (out_free) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			gx_sq_s2 <= gx_prod[SQ_W-1:0];
			gy_sq_s2 <= gy_prod[SQ_W-1:0];
			last_s2  <= q_head.frame_last;
		end
		if (out_free && valid_s2) begin
			data_s3.edge_value   <= (THR_SQ_W'(mag) >= thr_sq) ? EDGE_ON : EDGE_OFF;
			data_s3.magnitude_sq <= mag;
			data_s3.frame_last   <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

`ifndef SYNTH
	// The squared threshold is at least one, so a zero magnitude is never an edge.
	a_zero_not_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (data_s3.magnitude_sq == '0)) |-> data_s3.edge_value == EDGE_OFF)
		else $error("edge marked at zero magnitude");
`endif

endmodule

`default_nettype wire

// File: rtl/sobel_edge_threshold.sv
// Path: a result goes from the line read stage through the queue to registers s2 and s3;
// a pixel's own result is emitted by the item image_width+1 pixels later or by a flush.
// Throughput: one item per cycle while in_ready holds, set by one line store read and one
// write per pixel and a four-entry queue between the classifying front and arithmetic back.
// Reset: arst_n clears counters, window, queue and pipeline and loads the register
// defaults; the line stores are not cleared and hold nothing until written.
`default_nettype none

module sobel_edge_threshold import sobet_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data
);

	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int AW      = $clog2(MAX_WIDTH);
	localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	logic [WW-1:0]           img_width_q;
	logic [HGT_W-1:0]        img_height_q;
	logic [THR_SQ_W-1:0]     thr_sq_q;

	logic [31:0]             raw_ext;
	logic [WW-1:0]           width_sat;
	logic [HGT_W-1:0]        height_sat;
	logic [THR_W:0]          limit;
	logic [2*(THR_W+1)-1:0]  limit_sq;
	logic                    restart;

	logic [QCNT_W-1:0]       q_count;
	logic                    push;
	grad_t                   push_data;
	logic                    q_pop;
	grad_t                   q_head;
	logic                    q_not_empty;
	logic                    ram_rd_en;
	logic [AW-1:0]           ram_rd_addr;
	logic [2*PIX_W-1:0]      ram_rd_data;
	logic                    ram_wr_en;
	logic [AW-1:0]           ram_wr_addr;
	logic [2*PIX_W-1:0]      ram_wr_data;

	// Saturate the geometry and square the threshold limit as it is written.
	always_comb begin
		raw_ext = 32'(cfg_wdata);
		if (raw_ext < 32'(MIN_DIM)) begin
			width_sat = WW'(MIN_DIM);
		end else if (raw_ext > 32'(MAX_WIDTH)) begin
			width_sat = WW'(MAX_WIDTH);
		end else begin
			width_sat = WW'(raw_ext);
		end
		if (raw_ext < 32'(MIN_DIM)) begin
			height_sat = HGT_W'(MIN_DIM);
		end else if (raw_ext > 32'(MAX_HEIGHT)) begin
			height_sat = HGT_W'(MAX_HEIGHT);
		end else begin
			height_sat = HGT_W'(raw_ext);
		end
		limit    = {1'b0, cfg_wdata[THR_W-1:0]} + (THR_W+1)'(1);
		limit_sq = limit * limit;
	end

	// A geometry write restarts the stream.
	assign restart = cfg_wr_en
		&& ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= WW'(RESET_W);
			img_height_q <= HGT_W'(RESET_HEIGHT);
			thr_sq_q     <= RESET_THR_SQ;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					img_width_q <= width_sat;
				end
				REG_IMAGE_HEIGHT: begin
					img_height_q <= height_sat;
				end
				REG_EDGE_THRESHOLD: begin
					thr_sq_q <= limit_sq[THR_SQ_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sobet_ram #(
		.WIDTH(2 * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sobet_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.restart     (restart),
		.img_width   (img_width_q),
		.img_height  (img_height_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.q_count     (q_count),
		.push        (push),
		.push_data   (push_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data)
	);

	sobet_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	sobet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr_sq    (thr_sq_q),
		.q_valid   (q_not_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
